// ===== hdl/integer_alu_with_gcd_lcm_assert.svh =====
// Assertion macros used by the checker file.
`ifndef INTEGER_ALU_WITH_GCD_LCM_ASSERT_SVH
`define INTEGER_ALU_WITH_GCD_LCM_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define IALU_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define IALU_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

// ===== hdl/ialu_pkg.sv =====
// -----------------------------------------------------------------------------
// ialu_pkg
// Shared types and codes for the multicycle integer ALU.
// -----------------------------------------------------------------------------
`default_nettype none
package ialu_pkg;
    localparam int DataWidth = 32;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3, OP_MOD = 4'd4,
        OP_POW = 4'd5, OP_MAX = 4'd6, OP_MIN = 4'd7, OP_GCD = 4'd8, OP_LCM = 4'd9
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_DIV_ZERO = 2'd1, ST_BAD_OP = 2'd2
    } status_t;

    // Datapath commands.
    typedef enum logic [3:0] {
        CMD_NONE,      // hold
        CMD_LOAD,      // latch opcode and operands
        CMD_SIMPLE,    // add, sub, max, min into result
        CMD_MUL_START, // load multiplier: m_a=a, m_b=b, product=0
        CMD_MUL_STEP,  // one shift-add step
        CMD_DIV_START, // dividend=x, divisor=y, quotient cleared
        CMD_DIV_STEP,  // one restoring division step
        CMD_GCD_SETUP, // x=|a|, y=|b|
        CMD_GCD_NEXT,  // x=y, y=remainder
        CMD_POW_INIT,  // acc=1, base=a, exp=b
        CMD_POW_MUL_ACC,   // multiplier: acc*base
        CMD_POW_MUL_BASE,  // multiplier: base*base
        CMD_LCM_PROD,  // multiplier: a*b
        CMD_FINISH     // form result from selected source
    } cmd_t;

    typedef enum logic [3:0] {
        SRC_ZERO, SRC_MULP, SRC_QUOT_S, SRC_REM_S, SRC_GCD_X, SRC_POW, SRC_LCM, SRC_KEEP
    } src_t;

    typedef struct packed {
        cmd_t cmd;
        src_t src;
        logic pow_after_acc;  // after acc multiply, store into acc
    } ctl_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic y_zero;
        logic b_zero;
        logic a_zero;
        logic exp_zero;
        logic exp_lsb;
        logic exp_neg;
    } sts_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_MUL, S_DIV_RUN, S_GCD_CHK, S_GCD_DIV,
        S_POW_CHK, S_POW_ACC, S_POW_CHK_B, S_POW_BASE, S_LCM_MUL, S_LCM_DIV, S_FIN, S_OUT
    } state_t;
endpackage
`default_nettype wire

// ===== hdl/ialu_datapath.sv =====
// -----------------------------------------------------------------------------
// ialu_datapath
// Operand registers, shift-add multiplier, restoring divider and result.
// -----------------------------------------------------------------------------
`default_nettype none
module ialu_datapath
    import ialu_pkg::*;
#(
    parameter int DATA_WIDTH = DataWidth
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ctl_t                  ctl,
    input  wire logic [3:0]            opcode,
    input  wire logic [DATA_WIDTH-1:0] operand_a,
    input  wire logic [DATA_WIDTH-1:0] operand_b,
    output sts_t                       sts,
    output logic [DATA_WIDTH-1:0]      res
);
    localparam int W = DATA_WIDTH;
    localparam int CW = $clog2(W + 1);

    logic [3:0]   op_reg;
    logic [W-1:0] a_reg, b_reg, x_reg, y_reg, acc_reg, base_reg, exp_reg, res_reg;
    logic [W-1:0] m_a_reg, m_b_reg, m_p_reg;
    logic [W-1:0] q_reg, r_reg, d_reg, n_reg;
    logic [CW-1:0] cnt_reg;
    logic         mul_busy_reg, div_busy_reg;

    logic [W-1:0] mag_a, mag_b, trial, prod_mag;
    logic         sa, sb;
    logic [W:0]   rsh;

    always_comb
    begin
        sa = a_reg[W-1];
        sb = b_reg[W-1];
        mag_a = sa ? (~a_reg + 1'b1) : a_reg;
        mag_b = sb ? (~b_reg + 1'b1) : b_reg;
        prod_mag = m_p_reg[W-1] ? (~m_p_reg + 1'b1) : m_p_reg;
        rsh = {r_reg, n_reg[W-1]};
        trial = rsh[W-1:0] - d_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_busy_reg <= 1'b0;
            div_busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            case (ctl.cmd)
                CMD_MUL_START, CMD_POW_MUL_ACC, CMD_POW_MUL_BASE, CMD_LCM_PROD:
                begin
                    mul_busy_reg <= 1'b1;
                    cnt_reg <= CW'(W);
                end
                CMD_DIV_START:
                begin
                    div_busy_reg <= 1'b1;
                    cnt_reg <= CW'(W);
                end
                CMD_MUL_STEP, CMD_DIV_STEP:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1))
                    begin
                        mul_busy_reg <= 1'b0;
                        div_busy_reg <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctl.cmd)
            CMD_LOAD:
            begin
                op_reg <= opcode;
                a_reg <= operand_a;
                b_reg <= operand_b;
            end
            CMD_SIMPLE:
            begin
                case (op_reg)
                    OP_ADD: res_reg <= a_reg + b_reg;
                    OP_SUB: res_reg <= a_reg - b_reg;
                    OP_MAX: res_reg <= ($signed(a_reg) > $signed(b_reg)) ? a_reg : b_reg;
                    default: res_reg <= ($signed(b_reg) > $signed(a_reg)) ? a_reg : b_reg;
                endcase
            end
            CMD_MUL_START, CMD_LCM_PROD:
            begin
                m_a_reg <= a_reg;
                m_b_reg <= b_reg;
                m_p_reg <= '0;
            end
            CMD_POW_MUL_ACC:
            begin
                m_a_reg <= acc_reg;
                m_b_reg <= base_reg;
                m_p_reg <= '0;
            end
            CMD_POW_MUL_BASE:
            begin
                m_a_reg <= base_reg;
                m_b_reg <= base_reg;
                m_p_reg <= '0;
            end
            CMD_MUL_STEP:
            begin
                if (m_b_reg[0])
                    m_p_reg <= m_p_reg + m_a_reg;
                m_a_reg <= m_a_reg << 1;
                m_b_reg <= m_b_reg >> 1;
            end
            CMD_DIV_START:
            begin
                n_reg <= x_reg;
                d_reg <= y_reg;
                r_reg <= '0;
                q_reg <= '0;
            end
            CMD_DIV_STEP:
            begin
                n_reg <= n_reg << 1;
                if (rsh >= {1'b0, d_reg})
                begin
                    r_reg <= trial;
                    q_reg <= {q_reg[W-2:0], 1'b1};
                end
                else
                begin
                    r_reg <= rsh[W-1:0];
                    q_reg <= {q_reg[W-2:0], 1'b0};
                end
            end
            CMD_GCD_SETUP:
            begin
                x_reg <= mag_a;
                y_reg <= mag_b;
            end
            CMD_GCD_NEXT:
            begin
                x_reg <= y_reg;
                y_reg <= r_reg;
            end
            CMD_POW_INIT:
            begin
                acc_reg <= W'(1);
                base_reg <= a_reg;
                exp_reg <= b_reg;
            end
            CMD_FINISH:
            begin
                case (ctl.src)
                    SRC_ZERO: res_reg <= '0;
                    SRC_MULP:
                    begin
                        if (op_reg == OP_POW)
                        begin
                            if (ctl.pow_after_acc)
                                acc_reg <= m_p_reg;
                            else
                            begin
                                base_reg <= m_p_reg;
                                exp_reg <= exp_reg >> 1;
                            end
                        end
                        else if (op_reg == OP_LCM)
                        begin
                            // x holds the gcd: the product magnitude becomes the
                            // dividend and the gcd the divisor.
                            x_reg <= prod_mag;
                            y_reg <= x_reg;
                        end
                        else
                            res_reg <= m_p_reg;
                    end
                    SRC_QUOT_S: res_reg <= (sa != sb) ? (~q_reg + 1'b1) : q_reg;
                    SRC_REM_S: res_reg <= sa ? (~r_reg + 1'b1) : r_reg;
                    SRC_GCD_X: res_reg <= x_reg;
                    SRC_POW: res_reg <= acc_reg;
                    SRC_LCM: res_reg <= q_reg;
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        sts.mul_done = !mul_busy_reg;
        sts.div_done = !div_busy_reg;
        sts.y_zero = (y_reg == '0);
        sts.b_zero = (b_reg == '0);
        sts.a_zero = (a_reg == '0);
        sts.exp_zero = (exp_reg == '0);
        sts.exp_lsb = exp_reg[0];
        sts.exp_neg = b_reg[W-1];
        res = res_reg;
    end
endmodule
`default_nettype wire

// ===== hdl/ialu_ctrl.sv =====
// -----------------------------------------------------------------------------
// ialu_ctrl
// Sequencer: handshake, operation dispatch and status code.
// -----------------------------------------------------------------------------
`default_nettype none
module ialu_ctrl
    import ialu_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  wire logic  out_stall,
    input  wire logic [3:0] opcode_q,
    input  wire sts_t  sts,
    output ctl_t       ctl,
    output logic [1:0] status_code
);
    state_t state_reg, state_next;
    status_t st_reg, st_next;
    logic [3:0] op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg <= ST_OK;
            op_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            st_reg <= st_next;
            op_reg <= op_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        st_next = st_reg;
        op_next = op_reg;
        ctl.cmd = CMD_NONE;
        ctl.src = SRC_KEEP;
        ctl.pow_after_acc = 1'b0;
        in_stall = 1'b1;
        out_valid = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    ctl.cmd = CMD_LOAD;
                    op_next = opcode_q;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                st_next = ST_OK;
                case (op_reg)
                    OP_ADD, OP_SUB, OP_MAX, OP_MIN:
                    begin
                        ctl.cmd = CMD_SIMPLE;
                        state_next = S_OUT;
                    end
                    OP_MUL:
                    begin
                        ctl.cmd = CMD_MUL_START;
                        state_next = S_MUL;
                    end
                    OP_DIV, OP_MOD:
                    begin
                        ctl.cmd = CMD_GCD_SETUP;
                        if (sts.b_zero)
                        begin
                            st_next = ST_DIV_ZERO;
                            state_next = S_FIN;
                        end
                        else
                            state_next = S_GCD_DIV;
                    end
                    OP_GCD, OP_LCM:
                    begin
                        ctl.cmd = CMD_GCD_SETUP;
                        state_next = (op_reg == OP_LCM && (sts.a_zero || sts.b_zero))
                            ? S_FIN : S_GCD_CHK;
                    end
                    OP_POW:
                    begin
                        ctl.cmd = CMD_POW_INIT;
                        state_next = sts.exp_neg ? S_FIN : S_POW_CHK;
                    end
                    default:
                    begin
                        st_next = ST_BAD_OP;
                        state_next = S_FIN;
                    end
                endcase
            end
            S_MUL:
            begin
                if (!sts.mul_done)
                    ctl.cmd = CMD_MUL_STEP;
                else
                begin
                    ctl.cmd = CMD_FINISH;
                    ctl.src = SRC_MULP;
                    state_next = S_OUT;
                end
            end
            S_GCD_CHK:
            begin
                if (sts.y_zero)
                begin
                    if (op_reg == OP_LCM)
                    begin
                        ctl.cmd = CMD_LCM_PROD;
                        state_next = S_LCM_MUL;
                    end
                    else
                    begin
                        ctl.cmd = CMD_FINISH;
                        ctl.src = SRC_GCD_X;
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    ctl.cmd = CMD_DIV_START;
                    state_next = S_GCD_DIV;
                end
            end
            S_GCD_DIV:
            begin
                // Entered from dispatch for div/mod: start the divider first.
                if (sts.div_done && (op_reg == OP_DIV || op_reg == OP_MOD))
                begin
                    ctl.cmd = CMD_DIV_START;
                    state_next = S_DIV_RUN;
                end
                else if (!sts.div_done)
                    ctl.cmd = CMD_DIV_STEP;
                else
                begin
                    ctl.cmd = CMD_GCD_NEXT;
                    state_next = S_GCD_CHK;
                end
            end
            S_DIV_RUN:
            begin
                if (!sts.div_done)
                    ctl.cmd = CMD_DIV_STEP;
                else
                begin
                    ctl.cmd = CMD_FINISH;
                    ctl.src = (op_reg == OP_DIV) ? SRC_QUOT_S :
                              (op_reg == OP_MOD) ? SRC_REM_S : SRC_LCM;
                    state_next = S_OUT;
                end
            end
            S_LCM_MUL:
            begin
                if (!sts.mul_done)
                    ctl.cmd = CMD_MUL_STEP;
                else
                begin
                    ctl.cmd = CMD_FINISH;
                    ctl.src = SRC_MULP;
                    state_next = S_LCM_DIV;
                end
            end
            S_LCM_DIV:
            begin
                // Dividend and divisor were placed by the finish step; start the divider.
                ctl.cmd = CMD_DIV_START;
                state_next = S_DIV_RUN;
            end
            S_POW_CHK:
            begin
                if (sts.exp_zero)
                begin
                    ctl.cmd = CMD_FINISH;
                    ctl.src = SRC_POW;
                    state_next = S_OUT;
                end
                else if (sts.exp_lsb)
                begin
                    ctl.cmd = CMD_POW_MUL_ACC;
                    state_next = S_POW_ACC;
                end
                else
                begin
                    ctl.cmd = CMD_POW_MUL_BASE;
                    state_next = S_POW_BASE;
                end
            end
            S_POW_ACC:
            begin
                if (!sts.mul_done)
                    ctl.cmd = CMD_MUL_STEP;
                else
                begin
                    ctl.cmd = CMD_FINISH;
                    ctl.src = SRC_MULP;
                    ctl.pow_after_acc = 1'b1;
                    state_next = S_POW_CHK_B;
                end
            end
            S_POW_BASE:
            begin
                if (!sts.mul_done)
                    ctl.cmd = CMD_MUL_STEP;
                else
                begin
                    ctl.cmd = CMD_FINISH;
                    ctl.src = SRC_MULP;
                    state_next = S_POW_CHK;
                end
            end
            S_POW_CHK_B:
            begin
                ctl.cmd = CMD_POW_MUL_BASE;
                state_next = S_POW_BASE;
            end
            S_FIN:
            begin
                ctl.cmd = CMD_FINISH;
                ctl.src = SRC_ZERO;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    in_stall = 1'b0;
                    if (in_valid)
                    begin
                        ctl.cmd = CMD_LOAD;
                        op_next = opcode_q;
                        state_next = S_DISPATCH;
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
        status_code = st_reg;
    end
endmodule
`default_nettype wire

// ===== hdl/integer_alu_with_gcd_lcm.sv =====
// -----------------------------------------------------------------------------
// integer_alu_with_gcd_lcm
// Multicycle signed ALU with divide, power, gcd and lcm.
// -----------------------------------------------------------------------------
//  Channel  | Handshake            | Payload
//  input    | in_valid / in_stall  | opcode, operand_a, operand_b
//  output   | out_valid / out_stall| result_value, status_code
//
// Add, sub, max and min form their result straight from the operands; zero divisors,
// unknown codes and negative exponents go straight to a zero result.
// Mul runs on the shift-add multiplier and div/mod on the restoring divider;
// gcd runs one divide per Euclid step, and lcm adds a multiply and a divide.
// Power runs one multiply per exponent bit, and a second one when that bit is set.
// Reset clears the sequencer; a held result keeps the input stalled until taken.
`default_nettype none
module integer_alu_with_gcd_lcm
    import ialu_pkg::*;
#(
    parameter int DATA_WIDTH = DataWidth
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [3:0]            opcode,
    input  wire logic [DATA_WIDTH-1:0] operand_a,
    input  wire logic [DATA_WIDTH-1:0] operand_b,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [DATA_WIDTH-1:0]      result_value,
    output logic [1:0]                 status_code
);
    ctl_t ctl;
    sts_t sts;

    ialu_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
        .opcode_q(opcode), .sts, .ctl, .status_code
    );

    ialu_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
        .clk, .rst_n, .ctl, .opcode, .operand_a, .operand_b, .sts, .res(result_value)
    );
endmodule
`default_nettype wire

// ===== hdl/ialu_checker.sv =====
// -----------------------------------------------------------------------------
// ialu_checker
// Port-level checks for the ALU.
// -----------------------------------------------------------------------------
`default_nettype none
`include "integer_alu_with_gcd_lcm_assert.svh"
module ialu_checker
    import ialu_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [1:0] status_code
);
    `IALU_ASSERT_IMPL(a_status_range, clk, rst_n, out_valid, status_code != 2'd3)
    `IALU_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, !out_valid)
    `IALU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `IALU_ASSERT_IMPL(a_no_input_while_held, clk, rst_n, out_valid && out_stall, in_stall)
endmodule
bind integer_alu_with_gcd_lcm ialu_checker u_chk (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .status_code
);
`default_nettype wire

// ===== bench/tb.sv =====
// -----------------------------------------------------------------------------
// tb
// Self-checking bench for the multicycle integer ALU: directed corner items,
// then random items for every operation, with random sender gaps, receiver
// stalls and a long receiver hold that backs the block up.
// -----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import ialu_pkg::*;

    localparam int W = DataWidth;
    // The idle limit lies above both the slowest item (a power with a full-width
    // exponent) and the long receiver hold.
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 100;
    localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINUS_ONE = {W{1'b1}};

    typedef struct {
        logic [W-1:0] value;
        status_t      status;
    } alu_result_t;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    logic [3:0]    opcode;
    logic [W-1:0]  operand_a;
    logic [W-1:0]  operand_b;
    logic          out_valid;
    logic          out_stall;
    logic [W-1:0]  result_value;
    logic [1:0]    status_code;

    alu_result_t   pending_results[$];
    int            items_taken;
    int            results_taken;
    int            error_count;
    int            idle_cycles;
    int            burst_left;
    bit            hold_request;

    integer_alu_with_gcd_lcm dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value),
        .status_code  (status_code)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Magnitude of a two's complement value, read as unsigned.
    function automatic logic [W-1:0] magnitude_of(input logic [W-1:0] v);
        return v[W-1] ? -v : v;
    endfunction

    function automatic logic [W-1:0] euclid_gcd(input logic [W-1:0] x, input logic [W-1:0] y);
        logic [W-1:0] r;
        while (y != 0)
        begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    // Square-and-multiply, wrapping at the data width; negative exponents give zero.
    function automatic logic [W-1:0] wrapped_power(input logic [W-1:0] base,
                                                   input logic [W-1:0] expo);
        logic [W-1:0] acc;
        acc = 1;
        if (expo[W-1])
            return '0;
        while (expo != 0)
        begin
            if (expo[0])
                acc = acc * base;
            base = base * base;
            expo = expo >> 1;
        end
        return acc;
    endfunction

    // Works out the result the ALU must give for one item.
    function automatic alu_result_t alu_outcome(input logic [3:0] op, input logic [W-1:0] a,
                                                input logic [W-1:0] b);
        alu_result_t r;
        logic [W-1:0] g;
        r.value = '0;
        r.status = ST_OK;
        case (op)
            OP_ADD: r.value = a + b;
            OP_SUB: r.value = a - b;
            OP_MUL: r.value = a * b;
            OP_DIV:
                if (b == 0)
                    r.status = ST_DIV_ZERO;
                else
                begin
                    r.value = magnitude_of(a) / magnitude_of(b);
                    if (a[W-1] != b[W-1])
                        r.value = -r.value;
                end
            OP_MOD:
                if (b == 0)
                    r.status = ST_DIV_ZERO;
                else
                begin
                    r.value = magnitude_of(a) % magnitude_of(b);
                    if (a[W-1])
                        r.value = -r.value;
                end
            OP_POW: r.value = wrapped_power(a, b);
            OP_MAX: r.value = ($signed(a) > $signed(b)) ? a : b;
            OP_MIN: r.value = ($signed(b) > $signed(a)) ? a : b;
            OP_GCD: r.value = euclid_gcd(magnitude_of(a), magnitude_of(b));
            OP_LCM:
                if (a != 0 && b != 0)
                begin
                    g = euclid_gcd(magnitude_of(a), magnitude_of(b));
                    r.value = magnitude_of(a * b) / g;
                end
            default: r.status = ST_BAD_OP;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [W-1:0] got,
                                   input logic [W-1:0] want);
        error_count++;
        $display("MISMATCH %s: got %0h, expected %0h (result %0d)", what, got, want,
                 results_taken);
    endtask

    // Both handshakes are sampled at the rising edge. Inputs only change on the
    // falling edge, so the values seen here are settled.
    always @(posedge clk)
    begin
        alu_result_t want;
        if (rst_n && in_valid && !in_stall)
        begin
            pending_results.push_back(alu_outcome(opcode, operand_a, operand_b));
            items_taken++;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", result_value, '0);
            else
            begin
                want = pending_results.pop_front();
                if (result_value !== want.value)
                    report_mismatch("result_value", result_value, want.value);
                if (status_code !== want.status)
                    report_mismatch("status_code", W'(status_code), W'(want.status));
            end
            results_taken++;
        end
    end

    // Ends the run if the block stops moving items in either direction.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: nothing moved for %0d cycles", IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver stall pattern: the mode is redrawn at random among no stall at all,
    // light, alternating and heavy stalling. A hold request
    // stalls the output for a long counted stretch.
    initial
    begin
        int mode;
        int cycle;
        mode = 0;
        cycle = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                cycle++;
                if (cycle % 64 == 0)
                    mode = $urandom_range(0, 3);
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 9) < 3);
                    2: out_stall <= cycle[0];
                    default: out_stall <= ($urandom_range(0, 9) < 7);
                endcase
            end
        end
    end

    // Offers one item and returns on the falling edge after it is taken. Items
    // come in bursts; between bursts the valid usually drops for a random gap.
    task automatic send_item(input logic [3:0] op, input logic [W-1:0] a,
                             input logic [W-1:0] b);
        int taken_before;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        opcode <= op;
        operand_a <= a;
        operand_b <= b;
        taken_before = items_taken;
        wait (items_taken != taken_before);
        @(negedge clk);
    endtask

    // Pauses the sender until every expected result has come back.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(negedge clk);
    endtask

    // Operand mix: extremes, small values of either sign, and full random words.
    function automatic logic [W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return MOST_NEG;
            1: return MOST_POS;
            2: return MINUS_ONE;
            3: return $urandom_range(0, 2);
            4, 5: return $urandom_range(0, 200) - 100;
            6: return $urandom_range(0, 65535) << $urandom_range(0, 16);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        send_item(OP_ADD, MOST_POS, 1);
        send_item(OP_SUB, MOST_NEG, 1);
        send_item(OP_MUL, MOST_NEG, MINUS_ONE);
        send_item(OP_MUL, 32'h0001_0000, 32'h0001_0000);
        // Division and remainder by zero report the divide-by-zero status.
        send_item(OP_DIV, 7, 0);
        send_item(OP_MOD, MOST_NEG, 0);
        // The most negative value over minus one wraps; its remainder is zero.
        send_item(OP_DIV, MOST_NEG, MINUS_ONE);
        send_item(OP_MOD, MOST_NEG, MINUS_ONE);
        send_item(OP_DIV, -7, 2);
        send_item(OP_MOD, -7, 2);
        send_item(OP_MOD, 7, -2);
        // Negative exponents give zero; a zero exponent gives one.
        send_item(OP_POW, 3, MINUS_ONE);
        send_item(OP_POW, MOST_NEG, 0);
        send_item(OP_POW, 3, 40);
        send_item(OP_POW, MINUS_ONE, MOST_POS);
        send_item(OP_MAX, MOST_NEG, MOST_POS);
        send_item(OP_MIN, MOST_NEG, MOST_POS);
        send_item(OP_MAX, -5, -5);
        // A gcd of the most negative value wraps back to it; gcd of zeros is zero.
        send_item(OP_GCD, MOST_NEG, 0);
        send_item(OP_GCD, 0, 0);
        send_item(OP_GCD, -12, 18);
        send_item(OP_LCM, 0, 5);
        send_item(OP_LCM, MOST_NEG, MOST_NEG);
        send_item(OP_LCM, -4, 6);
        // Codes past the last operation are unknown.
        send_item(4'd10, 1, 2);
        send_item(4'd15, MINUS_ONE, MINUS_ONE);
        wait_for_drain();
    endtask

    task automatic test_simple_and_unknown();
        int op;
        repeat (400)
        begin
            op = $urandom_range(0, 9);
            case (op)
                0: send_item(OP_ADD, pick_operand(), pick_operand());
                1: send_item(OP_SUB, pick_operand(), pick_operand());
                2, 3: send_item(OP_MUL, pick_operand(), pick_operand());
                4: send_item(OP_MAX, pick_operand(), pick_operand());
                5: send_item(OP_MIN, pick_operand(), pick_operand());
                6: send_item(4'($urandom_range(10, 15)), $urandom, $urandom);
                default: send_item(OP_MUL, $urandom, $urandom);
            endcase
        end
    endtask

    task automatic test_divide();
        logic [W-1:0] divisor;
        repeat (250)
        begin
            divisor = ($urandom_range(0, 9) == 0) ? '0 : pick_operand();
            if ($urandom_range(0, 1) == 0)
                send_item(OP_DIV, pick_operand(), divisor);
            else
                send_item(OP_MOD, pick_operand(), divisor);
        end
    endtask

    task automatic test_power();
        logic [W-1:0] expo;
        int count;
        for (count = 0; count < 120; count++)
        begin
            // Long exponents are slow, so only a few items use them.
            if (count % 12 == 0)
                expo = $urandom & MOST_POS;
            else if ($urandom_range(0, 7) == 0)
                expo = $urandom | MOST_NEG;
            else
                expo = $urandom_range(0, 40);
            send_item(OP_POW, pick_operand(), expo);
        end
    endtask

    task automatic test_gcd_lcm();
        logic [W-1:0] factor;
        repeat (300)
        begin
            // Shared factors make gcd and lcm results more interesting.
            factor = $urandom_range(1, 1000);
            if ($urandom_range(0, 1) == 0)
                send_item(OP_GCD, pick_operand(), factor * $urandom_range(0, 5000));
            else if ($urandom_range(0, 1) == 0)
                send_item(OP_LCM, factor * ($urandom_range(0, 4000) - 2000),
                          factor * $urandom_range(0, 3000));
            else
                send_item(OP_LCM, pick_operand(), pick_operand());
        end
    endtask

    // The receiver holds off while items keep coming, so the block fills and
    // must stall its input; afterwards the sender waits for a full drain.
    task automatic test_backpressure();
        hold_request = 1'b1;
        repeat (60)
            send_item(4'($urandom_range(0, 9)), pick_operand(), $urandom_range(0, 20));
        wait (!hold_request);
        wait_for_drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = '0;
        operand_a = '0;
        operand_b = '0;
        items_taken = 0;
        results_taken = 0;
        error_count = 0;
        idle_cycles = 0;
        burst_left = 0;
        hold_request = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_simple_and_unknown();
        test_divide();
        test_power();
        test_gcd_lcm();
        test_backpressure();

        wait_for_drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+hdl
hdl/ialu_pkg.sv
hdl/ialu_datapath.sv
hdl/ialu_ctrl.sv
hdl/integer_alu_with_gcd_lcm.sv
hdl/ialu_checker.sv
bench/tb.sv
